[sv/complex_arithmetic_unit_assert.svh]
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CAU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(label, ante, cons)
`define CAU_ASSERT_NXT(label, ante, cons)
`endif

`endif

[sv/cau_pkg.sv]
// types and codes shared by the complex arithmetic unit
`default_nettype none

package cau_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_MUL  = 2'd1,
        MODE_DIV  = 2'd2,
        MODE_CONJ = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [FIELD_W-1:0] a_re;
        logic signed [FIELD_W-1:0] a_im;
        logic signed [FIELD_W-1:0] b_re;
        logic signed [FIELD_W-1:0] b_im;
    } cau_op_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] r_re;
        logic signed [FIELD_W-1:0] r_im;
        logic                      overflow;
        logic                      div_zero;
    } cau_res_t;

endpackage

`default_nettype wire

[sv/complex_arithmetic_unit.sv]
// complex arithmetic unit: add, multiply, divide and conjugate in signed fixed point
//
// Operation channel op_valid / op_stall / op carries the mode and the two
// complex operands; result channel res_valid / res_stall / res carries the
// saturated result with its overflow and divide-by-zero flags.
// A transfer takes place on a rising clock edge with valid high and stall low.
// Operands use the low DATA_WIDTH bits of each field with FRAC_BITS fraction
// bits; results are sign-extended to the full field width.
// Pipeline stages, in order: input register,
// product stage, sum stage, sign and saturation stage, divider setup, one
// stage per quotient bit of the restoring divider, and the output register.
// Throughput is one item per cycle unless the output stalls; every mode uses the same stages.
// When res_stall holds a valid result the whole pipeline freezes and op_stall
// rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the datapath registers are not reset.
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     op_valid,
    output logic          op_stall,
    input  wire cau_op_t  op,
    output logic          res_valid,
    input  wire logic     res_stall,
    output cau_res_t      res
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int MW = 2 * W;
    localparam int NW = 2 * W + F;
    localparam int QB = W + 1;
    localparam int HW = NW - QB;
    localparam int RW = 2 * W;
    localparam int CW = (HW > RW) ? HW : RW;
    localparam int NS = QB + 6;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [QB-1:0] Q_HI  = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] Q_NEG = {2'b01, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic [MW-1:0]         mag_re;
        logic [MW-1:0]         mag_im;
        logic [MW-1:0]         den;
        logic signed [W-1:0]   r_re;
        logic signed [W-1:0]   r_im;
        logic                  ov;
    } sgn_t;

    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovh_re;
        logic                  ovh_im;
        logic [MW-1:0]         den;
        logic [RW-1:0]         rem_re;
        logic [RW-1:0]         rem_im;
        logic [QB-1:0]         low_re;
        logic [QB-1:0]         low_im;
        logic [QB-1:0]         q_re;
        logic [QB-1:0]         q_im;
        logic signed [W-1:0]   r_re;
        logic signed [W-1:0]   r_im;
        logic                  ov;
    } div_t;

    logic                 adv;
    logic [NS-1:0]        vld_reg;

    mode_t                s0_mode_reg;
    logic signed [W-1:0]  s0_ar_reg, s0_ai_reg, s0_br_reg, s0_bi_reg;

    mode_t                s1_mode_reg;
    logic signed [W-1:0]  s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [PW-1:0] s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg;
    logic signed [PW-1:0] s1_bb_r_reg, s1_bb_i_reg;

    mode_t                s2_mode_reg;
    logic signed [SW-1:0] s2_re_reg, s2_im_reg;
    logic [MW-1:0]        s2_den_reg;
    logic signed [SW-1:0] s2_re_next, s2_im_next;
    logic [MW-1:0]        s2_den_next;

    sgn_t                 s3_reg, s3_next;
    logic signed [SW-1:0] v_re, v_im;

    logic [NW-1:0]        n_re, n_im;
    div_t                 d_reg  [0:QB];
    div_t                 d0_next;
    div_t                 d_next [1:QB];
    logic [RW:0]          t_re [1:QB];
    logic [RW:0]          t_im [1:QB];

    cau_res_t             res_reg, res_next;
    logic                 sat_re, sat_im;
    logic [QB-1:0]        nq_re, nq_im;

    assign adv       = !vld_reg[NS-1] || !res_stall;
    assign op_stall  = !adv;
    assign res_valid = vld_reg[NS-1];
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], op_valid};
        end
    end

    // operand capture and products, plus the registers of the sum, sign, divider setup and output stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_mode_reg <= op.mode;
            s0_ar_reg   <= op.a_re[W-1:0];
            s0_ai_reg   <= op.a_im[W-1:0];
            s0_br_reg   <= op.b_re[W-1:0];
            s0_bi_reg   <= op.b_im[W-1:0];

            s1_mode_reg <= s0_mode_reg;
            s1_ar_reg   <= s0_ar_reg;
            s1_ai_reg   <= s0_ai_reg;
            s1_br_reg   <= s0_br_reg;
            s1_bi_reg   <= s0_bi_reg;
            s1_rr_reg   <= s0_ar_reg * s0_br_reg;
            s1_ii_reg   <= s0_ai_reg * s0_bi_reg;
            s1_ri_reg   <= s0_ar_reg * s0_bi_reg;
            s1_ir_reg   <= s0_ai_reg * s0_br_reg;
            s1_bb_r_reg <= s0_br_reg * s0_br_reg;
            s1_bb_i_reg <= s0_bi_reg * s0_bi_reg;

            s2_mode_reg <= s1_mode_reg;
            s2_re_reg   <= s2_re_next;
            s2_im_reg   <= s2_im_next;
            s2_den_reg  <= s2_den_next;

            s3_reg      <= s3_next;
            d_reg[0]    <= d0_next;
            res_reg     <= res_next;
        end
    end

    always_comb
    begin
        s2_den_next = MW'($unsigned(s1_bb_r_reg)) + MW'($unsigned(s1_bb_i_reg));
        case (s1_mode_reg)
            MODE_ADD:
            begin
                s2_re_next = SW'(s1_ar_reg) + SW'(s1_br_reg);
                s2_im_next = SW'(s1_ai_reg) + SW'(s1_bi_reg);
            end
            MODE_MUL:
            begin
                s2_re_next = SW'(s1_rr_reg) - SW'(s1_ii_reg);
                s2_im_next = SW'(s1_ri_reg) + SW'(s1_ir_reg);
            end
            MODE_DIV:
            begin
                s2_re_next = SW'(s1_rr_reg) + SW'(s1_ii_reg);
                s2_im_next = SW'(s1_ir_reg) - SW'(s1_ri_reg);
            end
            default:
            begin
                s2_re_next = SW'(s1_ar_reg);
                s2_im_next = -SW'(s1_ai_reg);
            end
        endcase
    end

    // sign split for divide, scaling for multiply, saturation for add, multiply and conjugate
    always_comb
    begin
        v_re = (s2_mode_reg == MODE_MUL) ? (s2_re_reg >>> F) : s2_re_reg;
        v_im = (s2_mode_reg == MODE_MUL) ? (s2_im_reg >>> F) : s2_im_reg;

        s3_next.is_div = (s2_mode_reg == MODE_DIV);
        s3_next.dz     = (s2_den_reg == '0);
        s3_next.den    = s2_den_reg;
        s3_next.neg_re = s2_re_reg[SW-1];
        s3_next.neg_im = s2_im_reg[SW-1];
        s3_next.mag_re = s2_re_reg[SW-1] ? MW'(-s2_re_reg) : MW'(s2_re_reg);
        s3_next.mag_im = s2_im_reg[SW-1] ? MW'(-s2_im_reg) : MW'(s2_im_reg);

        if (v_re > SAT_HI)
            s3_next.r_re = VAL_MAX;
        else if (v_re < SAT_LO)
            s3_next.r_re = VAL_MIN;
        else
            s3_next.r_re = v_re[W-1:0];

        if (v_im > SAT_HI)
            s3_next.r_im = VAL_MAX;
        else if (v_im < SAT_LO)
            s3_next.r_im = VAL_MIN;
        else
            s3_next.r_im = v_im[W-1:0];

        s3_next.ov = (v_re > SAT_HI) || (v_re < SAT_LO)
                  || (v_im > SAT_HI) || (v_im < SAT_LO);
    end

    // divider setup: high quotient part flags saturation up front
    always_comb
    begin
        n_re = NW'(s3_reg.mag_re) << F;
        n_im = NW'(s3_reg.mag_im) << F;

        d0_next.is_div = s3_reg.is_div;
        d0_next.dz     = s3_reg.dz;
        d0_next.neg_re = s3_reg.neg_re;
        d0_next.neg_im = s3_reg.neg_im;
        d0_next.den    = s3_reg.den;
        d0_next.ovh_re = CW'(n_re[NW-1:QB]) >= CW'(s3_reg.den);
        d0_next.ovh_im = CW'(n_im[NW-1:QB]) >= CW'(s3_reg.den);
        d0_next.rem_re = RW'(n_re[NW-1:QB]);
        d0_next.rem_im = RW'(n_im[NW-1:QB]);
        d0_next.low_re = n_re[QB-1:0];
        d0_next.low_im = n_im[QB-1:0];
        d0_next.q_re   = '0;
        d0_next.q_im   = '0;
        d0_next.r_re   = s3_reg.r_re;
        d0_next.r_im   = s3_reg.r_im;
        d0_next.ov     = s3_reg.ov;
    end

    // one restoring step per stage
    always_comb
    begin
        for (int k = 1; k <= QB; k++)
        begin
            t_re[k] = {d_reg[k-1].rem_re, d_reg[k-1].low_re[QB-1]};
            t_im[k] = {d_reg[k-1].rem_im, d_reg[k-1].low_im[QB-1]};
            d_next[k]        = d_reg[k-1];
            d_next[k].low_re = d_reg[k-1].low_re << 1;
            d_next[k].low_im = d_reg[k-1].low_im << 1;
            if (t_re[k] >= {1'b0, d_reg[k-1].den})
            begin
                d_next[k].rem_re = RW'(t_re[k] - {1'b0, d_reg[k-1].den});
                d_next[k].q_re   = {d_reg[k-1].q_re[QB-2:0], 1'b1};
            end
            else
            begin
                d_next[k].rem_re = t_re[k][RW-1:0];
                d_next[k].q_re   = {d_reg[k-1].q_re[QB-2:0], 1'b0};
            end
            if (t_im[k] >= {1'b0, d_reg[k-1].den})
            begin
                d_next[k].rem_im = RW'(t_im[k] - {1'b0, d_reg[k-1].den});
                d_next[k].q_im   = {d_reg[k-1].q_im[QB-2:0], 1'b1};
            end
            else
            begin
                d_next[k].rem_im = t_im[k][RW-1:0];
                d_next[k].q_im   = {d_reg[k-1].q_im[QB-2:0], 1'b0};
            end
        end
    end

    for (genvar g = 1; g <= QB; g++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[g] <= d_next[g];
            end
        end
    end

    // quotient clamp and result selection
    always_comb
    begin
        nq_re  = -d_reg[QB].q_re;
        nq_im  = -d_reg[QB].q_im;
        sat_re = d_reg[QB].ovh_re
              || (d_reg[QB].neg_re ? (d_reg[QB].q_re > Q_NEG) : (d_reg[QB].q_re > Q_HI));
        sat_im = d_reg[QB].ovh_im
              || (d_reg[QB].neg_im ? (d_reg[QB].q_im > Q_NEG) : (d_reg[QB].q_im > Q_HI));

        res_next = '0;
        if (!d_reg[QB].is_div)
        begin
            res_next.r_re     = FIELD_W'(d_reg[QB].r_re);
            res_next.r_im     = FIELD_W'(d_reg[QB].r_im);
            res_next.overflow = d_reg[QB].ov;
        end
        else if (d_reg[QB].dz)
        begin
            res_next.div_zero = 1'b1;
        end
        else
        begin
            if (sat_re)
                res_next.r_re = FIELD_W'(d_reg[QB].neg_re ? VAL_MIN : VAL_MAX);
            else if (d_reg[QB].neg_re)
                res_next.r_re = FIELD_W'($signed(nq_re[W-1:0]));
            else
                res_next.r_re = FIELD_W'($signed(d_reg[QB].q_re[W-1:0]));
            if (sat_im)
                res_next.r_im = FIELD_W'(d_reg[QB].neg_im ? VAL_MIN : VAL_MAX);
            else if (d_reg[QB].neg_im)
                res_next.r_im = FIELD_W'($signed(nq_im[W-1:0]));
            else
                res_next.r_im = FIELD_W'($signed(d_reg[QB].q_im[W-1:0]));
            res_next.overflow = sat_re || sat_im;
        end
    end

    `CAU_ASSERT_IMP(a_stall_from_output, op_stall, res_valid && res_stall)
    `CAU_ASSERT_IMP(a_dz_clean, res_valid && res.div_zero, res.r_re == '0 && res.r_im == '0 && !res.overflow)
    `CAU_ASSERT_IMP(a_re_extended, res_valid, (res.r_re[FIELD_W-1:W-1] == '0) || (res.r_re[FIELD_W-1:W-1] == '1))
    `CAU_ASSERT_IMP(a_im_extended, res_valid, (res.r_im[FIELD_W-1:W-1] == '0) || (res.r_im[FIELD_W-1:W-1] == '1))
    `CAU_ASSERT_NXT(a_freeze, res_valid && res_stall, vld_reg == $past(vld_reg))

endmodule

`default_nettype wire

[bench/complex_arithmetic_unit_test.sv]
// self-checking testbench for the complex arithmetic unit
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int LIMIT = 400000;
    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE = 32'sh00010000;
    localparam logic signed [127:0] WMAX = 128'sd2147483647;
    localparam logic signed [127:0] WMIN = -128'sd2147483648;

    typedef struct {
        cau_op_t  op;
        bit       known;
        cau_res_t res;
    } vector_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     op_valid = 1'b0;
    logic     op_stall;
    cau_op_t  op = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    cau_res_t res;

    cau_res_t result_q[$];
    vector_t  vectors[$];
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       hold_cycles = 0;
    int       mismatches = 0;
    int       results_seen = 0;
    int       cycles = 0;
    int       mode_count[4];

    complex_arithmetic_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .op_valid(op_valid), .op_stall(op_stall), .op(op),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [31:0] saturate(input logic signed [127:0] v,
                                                    inout bit ov);
        if (v > WMAX)
        begin
            ov = 1'b1;
            return VMAX;
        end
        if (v < WMIN)
        begin
            ov = 1'b1;
            return VMIN;
        end
        return v[31:0];
    endfunction

    // quotient scaled by the fraction bits, truncated toward zero
    function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] n,
                                                            input logic signed [127:0] d);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (n < 0) ? -n : n;
        q = (mag <<< FRAC) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic cau_res_t complex_result(input cau_op_t x);
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        cau_res_t r;
        bit ov;
        ar = x.a_re;
        ai = x.a_im;
        br = x.b_re;
        bi = x.b_im;
        r = '0;
        ov = 1'b0;
        re = 0;
        im = 0;
        case (x.mode)
            MODE_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_MUL:
            begin
                re = (ar * br - ai * bi) >>> FRAC;
                im = (ar * bi + ai * br) >>> FRAC;
            end
            MODE_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.div_zero = 1'b1;
                    return r;
                end
                re = scaled_quotient(ar * br + ai * bi, den);
                im = scaled_quotient(ai * br - ar * bi, den);
            end
            default:
            begin
                re = ar;
                im = -ai;
            end
        endcase
        r.r_re = saturate(re, ov);
        r.r_im = saturate(im, ov);
        r.overflow = ov;
        return r;
    endfunction

    function automatic logic signed [31:0] random_part();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? VMAX : VMIN;
            1: return $signed($urandom_range(32'h1fffff)) - 32'sh100000;
            2: return $signed($urandom_range(1, 0)) * ONE;
            3: return $signed($urandom_range(32'hffff)) - 32'sh8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cau_op_t random_op();
        cau_op_t x;
        x.mode = mode_t'($urandom_range(3));
        x.a_re = random_part();
        x.a_im = random_part();
        x.b_re = random_part();
        x.b_im = random_part();
        if (x.mode == MODE_DIV && $urandom_range(19) == 0)
        begin
            x.b_re = 0;
            x.b_im = 0;
        end
        return x;
    endfunction

    task automatic send(input cau_op_t x, input bit known, input cau_res_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= x;
        op_valid <= 1'b1;
        do
            @(posedge clk);
        while (op_stall);
        result_q.push_back(known ? want : complex_result(x));
        mode_count[x.mode]++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send(random_op(), 1'b0, '0);
    endtask

    task automatic drain();
        op_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cau_res_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout with %0d results outstanding", result_q.size());
            $display("status: fail");
            $finish;
        end
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %h", res);
            end
            else
            begin
                want = result_q.pop_front();
                if (res.r_re !== want.r_re || res.r_im !== want.r_im ||
                    res.overflow !== want.overflow || res.div_zero !== want.div_zero)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: re %h/%h im %h/%h ov %b/%b dz %b/%b (exp/act)",
                                 want.r_re, res.r_re, want.r_im, res.r_im,
                                 want.overflow, res.overflow, want.div_zero, res.div_zero);
                end
            end
        end
    end

    initial
    begin
        vectors = '{
            '{'{MODE_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
            '{'{MODE_ADD, VMAX, VMIN, 32'sd1, -32'sd1}, 1'b1, '{VMAX, VMIN, 1'b1, 1'b0}},
            '{'{MODE_ADD, VMIN, VMAX, VMAX, VMIN}, 1'b1, '{-32'sd1, -32'sd1, 1'b0, 1'b0}},
            '{'{MODE_MUL, ONE, 32'sd0, ONE, 32'sd0}, 1'b1, '{ONE, 32'sd0, 1'b0, 1'b0}},
            '{'{MODE_MUL, VMIN, VMIN, VMIN, VMIN}, 1'b0, '0},
            '{'{MODE_MUL, VMAX, VMIN, VMIN, VMAX}, 1'b0, '0},
            '{'{MODE_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b0, '0},
            '{'{MODE_MUL, -32'sd3, 32'sd5, ONE + 32'sd7, -32'sd9}, 1'b0, '0},
            '{'{MODE_DIV, ONE, ONE, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b1}},
            '{'{MODE_DIV, VMIN, VMAX, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b1}},
            '{'{MODE_DIV, ONE, 32'sd0, ONE, 32'sd0}, 1'b1, '{ONE, 32'sd0, 1'b0, 1'b0}},
            '{'{MODE_DIV, VMAX, VMIN, 32'sd1, 32'sd0}, 1'b0, '0},
            '{'{MODE_DIV, VMIN, VMIN, VMIN, VMIN}, 1'b0, '0},
            '{'{MODE_DIV, -32'sd1, 32'sd1, 32'sd3, 32'sd0}, 1'b0, '0},
            '{'{MODE_DIV, VMAX, VMAX, 32'sd0, -32'sd1}, 1'b0, '0},
            '{'{MODE_DIV, 32'sd7, -32'sd5, ONE * 3, VMIN}, 1'b0, '0},
            '{'{MODE_CONJ, VMAX, VMIN, 32'sd0, 32'sd0}, 1'b1, '{VMAX, VMAX, 1'b1, 1'b0}},
            '{'{MODE_CONJ, VMIN, VMAX, VMAX, VMIN}, 1'b1, '{VMIN, -VMAX, 1'b0, 1'b0}},
            '{'{MODE_CONJ, -32'sd1, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{-32'sd1, 32'sd0, 1'b0, 1'b0}}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            send(vectors[i].op, vectors[i].known, vectors[i].res);

        send_random(500);
        idle_pct = 51;
        send_random(500);
        drain();
        idle_pct = 0;
        stall_pct = 51;
        send_random(500);

        // long receiver hold so the pipeline fills and backs up
        hold_cycles <= 300;
        send_random(150);
        drain();

        idle_pct = 23;
        stall_pct = 23;
        send_random(500);
        op_valid <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("%0d transfers checked: add %0d, mul %0d, div %0d, conj %0d",
                 results_seen, mode_count[MODE_ADD], mode_count[MODE_MUL],
                 mode_count[MODE_DIV], mode_count[MODE_CONJ]);
        $display("mismatches %0d under free-flow, sparse, stalled and backed-up traffic",
                 mismatches);
        if (mismatches == 0 && result_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/cau_pkg.sv
sv/complex_arithmetic_unit.sv
bench/complex_arithmetic_unit_test.sv
